// ----- rtl/pbc_pkg.sv -----
// Shared types and constants of the pixel blit core.
package pbc_pkg;

    localparam int unsigned DIM_W   = 12;
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned POS_W   = 13;   // origin plus counter, no wrap
    localparam int unsigned CFG_IDX_W = 4;

    localparam int unsigned RED_SHIFT   = 16;
    localparam int unsigned GREEN_SHIFT = 8;

    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 12'd800;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 12'd600;
    localparam logic [DIM_W-1:0] AREA_DIM_RST      = 12'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 4'd0,
        REG_SCREEN_HEIGHT = 4'd1,
        REG_ORIGIN_X      = 4'd2,
        REG_ORIGIN_Y      = 4'd3,
        REG_AREA_WIDTH    = 4'd4,
        REG_AREA_HEIGHT   = 4'd5,
        REG_KEY_COLOR     = 4'd6,
        REG_RING_COLOR    = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   screen_width;
        logic [DIM_W-1:0]   screen_height;
        logic [DIM_W-1:0]   origin_x;
        logic [DIM_W-1:0]   origin_y;
        logic [DIM_W-1:0]   area_width;
        logic [DIM_W-1:0]   area_height;
        logic [COLOR_W-1:0] key_color;
        logic [COLOR_W-1:0] ring_color;
    } t_cfg;

    // Position flags of the pixel the walker points at.
    typedef struct packed {
        logic ring;
        logic done;
    } t_walk_flags;

endpackage

// ----- rtl/pbc_cfg_regs.sv -----
// Configuration register file of the pixel blit core.
module pbc_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pbc_pkg::COLOR_W-1:0]      i_cfg_data,
    output pbc_pkg::t_cfg                    o_cfg
);
    import pbc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= SCREEN_WIDTH_RST;
            r_cfg.screen_height <= SCREEN_HEIGHT_RST;
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
            r_cfg.area_width    <= AREA_DIM_RST;
            r_cfg.area_height   <= AREA_DIM_RST;
            r_cfg.key_color     <= '0;
            r_cfg.ring_color    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[DIM_W-1:0];
                REG_ORIGIN_X:      r_cfg.origin_x      <= i_cfg_data[DIM_W-1:0];
                REG_ORIGIN_Y:      r_cfg.origin_y      <= i_cfg_data[DIM_W-1:0];
                REG_AREA_WIDTH:    r_cfg.area_width    <= i_cfg_data[DIM_W-1:0];
                REG_AREA_HEIGHT:   r_cfg.area_height   <= i_cfg_data[DIM_W-1:0];
                REG_KEY_COLOR:     r_cfg.key_color     <= i_cfg_data;
                REG_RING_COLOR:    r_cfg.ring_color    <= i_cfg_data;
                default: ;  // unmapped index, drop
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/pbc_walk.sv -----
// Column and row counters that walk the area in raster order.
module pbc_walk #(
    parameter int unsigned MAX_DIM = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbc_pkg::t_cfg                 i_cfg,
    input  logic                          i_advance,
    output logic [$clog2(MAX_DIM)-1:0]    o_col,
    output logic [$clog2(MAX_DIM)-1:0]    o_row,
    output pbc_pkg::t_walk_flags          o_flags
);
    import pbc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_DIM);

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [CW-1:0] w_last, h_last;
    logic          last_col, last_row;

    // Clamp a size register to 1..MAX_DIM and return size minus one.
    function automatic logic [CW-1:0] dim_last(input logic [DIM_W-1:0] v);
        logic [DIM_W:0] wide;
        begin
            wide = {1'b0, v};
            if (v == '0)
                dim_last = '0;
            else if (wide > (DIM_W+1)'(MAX_DIM))
                dim_last = CW'(MAX_DIM - 1);
            else
                dim_last = CW'(wide - 1'b1);
        end
    endfunction

    always_comb begin
        w_last   = dim_last(i_cfg.area_width);
        h_last   = dim_last(i_cfg.area_height);
        last_col = (r_col >= w_last);
        last_row = (r_row >= h_last);
        n_col    = r_col;
        n_row    = r_row;
        if (i_advance) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col        = r_col;
    assign o_row        = r_row;
    assign o_flags.ring = (r_col == '0) || (r_row == '0) || last_col || last_row;
    assign o_flags.done = last_col && last_row;

endmodule

// ----- rtl/pbc_pixel.sv -----
// Two-register pixel path: input register, color/clip/address logic, result register.
module pbc_pixel #(
    parameter int unsigned MAX_DIM         = 2048,
    parameter int unsigned BYTES_PER_PIXEL = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbc_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pbc_pkg::COLOR_W-1:0]   i_src_color,
    input  logic                          i_outline,
    input  logic [$clog2(MAX_DIM)-1:0]    i_col,
    input  logic [$clog2(MAX_DIM)-1:0]    i_row,
    input  pbc_pkg::t_walk_flags          i_flags,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_we,
    output logic [pbc_pkg::COLOR_W-1:0]   o_offset,
    output logic [pbc_pkg::COLOR_W-1:0]   o_color,
    output logic                          o_done
);
    import pbc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_DIM);

    // input register
    logic                r_a_valid;
    logic [COLOR_W-1:0]  r_a_src;
    logic                r_a_outline;
    logic [CW-1:0]       r_a_col;
    logic [CW-1:0]       r_a_row;
    t_walk_flags         r_a_flags;

    // result register
    logic                r_b_valid;
    logic                r_b_we;
    logic [COLOR_W-1:0]  r_b_offset;
    logic [COLOR_W-1:0]  r_b_color;
    logic                r_b_done;

    logic                a_ready;
    logic [COLOR_W-1:0]  color;
    logic [POS_W-1:0]    pos_x, pos_y;
    logic                on_screen;
    logic                we;
    logic [2*POS_W-1:0]  prod;
    logic [COLOR_W-1:0]  linear;
    logic [COLOR_W-1:0]  offset;

    assign a_ready    = !r_b_valid || i_out_ready;
    assign o_in_ready = !r_a_valid || a_ready;

    always_comb begin
        color     = (r_a_outline && r_a_flags.ring) ? i_cfg.ring_color : r_a_src;
        pos_x     = POS_W'(i_cfg.origin_x) + POS_W'(r_a_col);
        pos_y     = POS_W'(i_cfg.origin_y) + POS_W'(r_a_row);
        on_screen = (pos_x < POS_W'(i_cfg.screen_width)) &&
                    (pos_y < POS_W'(i_cfg.screen_height));
        we        = on_screen && (color != i_cfg.key_color);
        prod      = (2*POS_W)'(pos_y) * (2*POS_W)'(i_cfg.screen_width);
        linear    = prod[COLOR_W-1:0] + COLOR_W'(pos_x);
        offset    = we ? COLOR_W'(linear * BYTES_PER_PIXEL) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (a_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_src     <= i_src_color;
            r_a_outline <= i_outline;
            r_a_col     <= i_col;
            r_a_row     <= i_row;
            r_a_flags   <= i_flags;
        end
        if (a_ready && r_a_valid) begin
            r_b_we     <= we;
            r_b_offset <= offset;
            r_b_color  <= color;
            r_b_done   <= r_a_flags.done;
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_we        = r_b_we;
    assign o_offset    = r_b_offset;
    assign o_color     = r_b_color;
    assign o_done      = r_b_done;

endmodule

// ----- rtl/pixel_blit_clip_colorkey_core.sv -----
// Top level of the pixel blit core: clip, color key and outline for a 24-bit framebuffer.
//
// Channel    | Dir | Handshake                      | Payload
// -----------+-----+--------------------------------+-------------------------------------
// s_axis     | in  | s_axis_tvalid / s_axis_tready  | tdata: red, green, blue; tuser: outline
// m_axis     | out | m_axis_tvalid / m_axis_tready  | tdata: offset, color; tuser: write enable;
//            |     |                                | tlast: last pixel of the area
// cfg        | in  | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One pixel per clock is sustained while m_axis_tready stays high. An accepted pixel
// passes the input register, then the color, clip and address logic (one 13x12
// multiply, an add and the scale by bytes per pixel) into the result register, which drives m_axis.
// Reset is synchronous and active low; it clears the counters, the pipeline valids and
// loads the register defaults. The config port is always ready.
// A stall on m_axis holds the result register, then the input register, then drops
// s_axis_tready; the walk counters advance only on accepted input beats.
module pixel_blit_clip_colorkey_core #(
    parameter int unsigned MAX_DIM         = 2048,
    parameter int unsigned BYTES_PER_PIXEL = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // source pixel stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic                              s_axis_tuser,   // [0] outline_mode

    // framebuffer write stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [47:0]                       m_axis_tdata,   // [23:0] byte_offset, [47:24] pixel_color
    output logic                              m_axis_tuser,   // [0] write_enable
    output logic                              m_axis_tlast,   // area_done

    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pbc_pkg::COLOR_W-1:0]       i_cfg_data
);
    import pbc_pkg::*;

    localparam int unsigned CW = $clog2(MAX_DIM);

    t_cfg               cfg;
    t_walk_flags        flags;
    logic [CW-1:0]      col, row;
    logic               in_accept;
    logic [COLOR_W-1:0] src_color;
    logic [COLOR_W-1:0] out_offset, out_color;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = s_axis_tvalid && s_axis_tready;

    // pack the source bytes as red<<16 | green<<8 | blue
    assign src_color = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

    pbc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // counters step once per accepted source beat
    pbc_walk #(
        .MAX_DIM (MAX_DIM)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (in_accept),
        .o_col     (col),
        .o_row     (row),
        .o_flags   (flags)
    );

    pbc_pixel #(
        .MAX_DIM         (MAX_DIM),
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
    ) u_pixel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_src_color (src_color),
        .i_outline   (s_axis_tuser),
        .i_col       (col),
        .i_row       (row),
        .i_flags     (flags),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_we        (m_axis_tuser),
        .o_offset    (out_offset),
        .o_color     (out_color),
        .o_done      (m_axis_tlast)
    );

    assign m_axis_tdata = {out_color, out_offset};

endmodule
